FILE: hdl/atan2p_pkg.sv
// shared types and constants for the atan2 angle pipeline
`timescale 1ns / 1ps
package atan2p_pkg;

    localparam int RATIO_BITS  = 16;
    localparam int ACC_BITS    = 18;
    localparam int HORNER_CELLS = 5;
    localparam int ANGLE_BITS  = 16;
    localparam int LATENCY     = 25;

    localparam logic signed [ANGLE_BITS-1:0] Q13_HALF_PI = 16'sd12868;
    localparam logic signed [ANGLE_BITS-1:0] Q13_PI      = 16'sd25736;
    localparam logic signed [ACC_BITS-1:0]   COEF_LEAD   = -18'sd883;

    typedef struct packed {
        logic valid;
        logic steep;
        logic xneg;
        logic yneg;
        logic zero;
        logic sat;
    } ctl_t;

    function automatic logic signed [ACC_BITS-1:0] horner_coef(input int idx);
        logic signed [ACC_BITS-1:0] c;
        case (idx)
            0:       c = 18'sd3767;
            1:       c = -18'sd7946;
            2:       c = 18'sd12821;
            3:       c = -18'sd21823;
            4:       c = 18'sd65536;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/atan2p_div_cell.sv
// one restoring division cell, one quotient bit per cycle
`timescale 1ns / 1ps
module atan2p_div_cell
    import atan2p_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_t                   ctl_in,
    input  logic [COORD_WIDTH-1:0] rem_in,
    input  logic [COORD_WIDTH-1:0] big_in,
    input  logic [RATIO_BITS-1:0]  quo_in,
    output ctl_t                   ctl_out,
    output logic [COORD_WIDTH-1:0] rem_out,
    output logic [COORD_WIDTH-1:0] big_out,
    output logic [RATIO_BITS-1:0]  quo_out
);

    logic [COORD_WIDTH:0]   rem2;
    logic [COORD_WIDTH:0]   diff;
    logic                   ge;
    logic [COORD_WIDTH-1:0] rem_next;
    logic                   valid_reg;
    ctl_t                   ctl_reg;
    logic [COORD_WIDTH-1:0] rem_reg;
    logic [COORD_WIDTH-1:0] big_reg;
    logic [RATIO_BITS-1:0]  quo_reg;

    always_comb
    begin
        rem2     = {rem_in, 1'b0};
        diff     = rem2 - {1'b0, big_in};
        ge       = rem2 >= {1'b0, big_in};
        rem_next = ge ? diff[COORD_WIDTH-1:0] : rem2[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_in;
        rem_reg <= rem_next;
        big_reg <= big_in;
        quo_reg <= {quo_in[RATIO_BITS-2:0], ge};
    end

    always_comb
    begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign rem_out = rem_reg;
    assign big_out = big_reg;
    assign quo_out = quo_reg;

endmodule

FILE: hdl/atan2p_horner_cell.sv
// one horner step: acc * s floored to q.16 plus the next coefficient
`timescale 1ns / 1ps
module atan2p_horner_cell
    import atan2p_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctl_t                       ctl_in,
    input  logic signed [ACC_BITS-1:0] acc_in,
    input  logic [RATIO_BITS-1:0]      sq_in,
    input  logic [RATIO_BITS-1:0]      r_in,
    output ctl_t                       ctl_out,
    output logic signed [ACC_BITS-1:0] acc_out,
    output logic [RATIO_BITS-1:0]      sq_out,
    output logic [RATIO_BITS-1:0]      r_out
);

    logic signed [ACC_BITS+RATIO_BITS:0] prod;
    logic signed [ACC_BITS+RATIO_BITS:0] prod_sh;
    logic signed [ACC_BITS-1:0]          acc_next;
    logic                                valid_reg;
    ctl_t                                ctl_reg;
    logic signed [ACC_BITS-1:0]          acc_reg;
    logic [RATIO_BITS-1:0]               sq_reg;
    logic [RATIO_BITS-1:0]               r_reg;

    always_comb
    begin
        prod     = acc_in * $signed({1'b0, sq_in});
        prod_sh  = prod >>> RATIO_BITS;
        acc_next = prod_sh[ACC_BITS-1:0] + horner_coef(STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_in;
        acc_reg <= acc_next;
        sq_reg  <= sq_in;
        r_reg   <= r_in;
    end

    always_comb
    begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign acc_out = acc_reg;
    assign sq_out  = sq_reg;
    assign r_out   = r_reg;

endmodule

FILE: hdl/atan2_polynomial_approx.sv
// start passes input, divider, square, horner, mul and done registers
// throughput one transaction per cycle, busy is never raised
// results cannot be stalled, each is shown for one cycle only
// the divider cell chain and the horner cell chain set the depth
// rst_n clears all valid flags asynchronously, data paths are not reset
`timescale 1ns / 1ps
module atan2_polynomial_approx
    import atan2p_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    output logic                          done,
    output logic signed [ANGLE_BITS-1:0]  angle
);

    ctl_t                   ctl_in;
    logic [COORD_WIDTH-1:0] ay;
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] big;
    logic [COORD_WIDTH-1:0] small_mag;
    logic                   in_valid_reg;
    ctl_t                   in_ctl_reg;
    ctl_t                   in_ctl;
    logic [COORD_WIDTH-1:0] rem0_reg;
    logic [COORD_WIDTH-1:0] big0_reg;

    ctl_t                   div_ctl [RATIO_BITS+1];
    logic [COORD_WIDTH-1:0] div_rem [RATIO_BITS+1];
    logic [COORD_WIDTH-1:0] div_big [RATIO_BITS+1];
    logic [RATIO_BITS-1:0]  div_quo [RATIO_BITS+1];

    logic [RATIO_BITS-1:0]     r_next;
    logic [2*RATIO_BITS-1:0]   sq_full;
    logic                      sq_valid_reg;
    ctl_t                      sq_ctl_reg;
    ctl_t                      sq_ctl;
    logic [RATIO_BITS-1:0]     sq_reg;
    logic [RATIO_BITS-1:0]     r_reg;

    ctl_t                       h_ctl [HORNER_CELLS+1];
    logic signed [ACC_BITS-1:0] h_acc [HORNER_CELLS+1];
    logic [RATIO_BITS-1:0]      h_sq  [HORNER_CELLS+1];
    logic [RATIO_BITS-1:0]      h_r   [HORNER_CELLS+1];

    logic signed [ACC_BITS+RATIO_BITS:0] fprod;
    logic signed [ACC_BITS+RATIO_BITS:0] fprod_sh;
    logic [RATIO_BITS:0]                 v_next;
    logic                                mul_valid_reg;
    ctl_t                                mul_ctl_reg;
    logic [RATIO_BITS:0]                 v_reg;

    logic [RATIO_BITS+1:0]        v_rnd;
    logic signed [ANGLE_BITS-1:0] a0;
    logic signed [ANGLE_BITS-1:0] a1;
    logic signed [ANGLE_BITS-1:0] a2;
    logic signed [ANGLE_BITS-1:0] angle_next;
    logic                         done_reg;
    logic signed [ANGLE_BITS-1:0] angle_reg;

    assign busy = 1'b0;

    // magnitudes and octant flags
    always_comb
    begin
        ay = coord_y[COORD_WIDTH-1] ? COORD_WIDTH'(-coord_y) : coord_y;
        ax = coord_x[COORD_WIDTH-1] ? COORD_WIDTH'(-coord_x) : coord_x;
        big       = (ay > ax) ? ay : ax;
        small_mag = (ay > ax) ? ax : ay;
        ctl_in.valid = start;
        ctl_in.steep = ay > ax;
        ctl_in.xneg  = coord_x[COORD_WIDTH-1];
        ctl_in.yneg  = coord_y[COORD_WIDTH-1];
        ctl_in.zero  = big == '0;
        ctl_in.sat   = small_mag == big;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            sq_valid_reg  <= div_ctl[RATIO_BITS].valid;
            mul_valid_reg <= h_ctl[HORNER_CELLS].valid;
            done_reg      <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_ctl_reg <= ctl_in;
        rem0_reg   <= small_mag;
        big0_reg   <= big;
    end

    always_comb
    begin
        in_ctl       = in_ctl_reg;
        in_ctl.valid = in_valid_reg;
    end

    assign div_ctl[0] = in_ctl;
    assign div_rem[0] = rem0_reg;
    assign div_big[0] = big0_reg;
    assign div_quo[0] = '0;

    for (genvar i = 0; i < RATIO_BITS; i++)
    begin : g_div
        atan2p_div_cell #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (div_ctl[i]),
            .rem_in  (div_rem[i]),
            .big_in  (div_big[i]),
            .quo_in  (div_quo[i]),
            .ctl_out (div_ctl[i+1]),
            .rem_out (div_rem[i+1]),
            .big_out (div_big[i+1]),
            .quo_out (div_quo[i+1])
        );
    end

    // equal magnitudes saturate the ratio
    always_comb
    begin
        r_next  = div_ctl[RATIO_BITS].sat ? '1 : div_quo[RATIO_BITS];
        sq_full = r_next * r_next;
    end

    always_ff @(posedge clk)
    begin
        sq_ctl_reg <= div_ctl[RATIO_BITS];
        sq_reg     <= sq_full[2*RATIO_BITS-1:RATIO_BITS];
        r_reg      <= r_next;
    end

    always_comb
    begin
        sq_ctl       = sq_ctl_reg;
        sq_ctl.valid = sq_valid_reg;
    end

    assign h_ctl[0] = sq_ctl;
    assign h_acc[0] = COEF_LEAD;
    assign h_sq[0]  = sq_reg;
    assign h_r[0]   = r_reg;

    for (genvar j = 0; j < HORNER_CELLS; j++)
    begin : g_horner
        atan2p_horner_cell #(
            .STEP(j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (h_ctl[j]),
            .acc_in  (h_acc[j]),
            .sq_in   (h_sq[j]),
            .r_in    (h_r[j]),
            .ctl_out (h_ctl[j+1]),
            .acc_out (h_acc[j+1]),
            .sq_out  (h_sq[j+1]),
            .r_out   (h_r[j+1])
        );
    end

    always_comb
    begin
        fprod    = h_acc[HORNER_CELLS] * $signed({1'b0, h_r[HORNER_CELLS]});
        fprod_sh = fprod >>> RATIO_BITS;
        v_next   = fprod_sh[ACC_BITS+RATIO_BITS] ? '0 : fprod_sh[RATIO_BITS:0];
    end

    always_ff @(posedge clk)
    begin
        mul_ctl_reg <= h_ctl[HORNER_CELLS];
        v_reg       <= v_next;
    end

    // round to q3.13 and fold into the octant
    always_comb
    begin
        v_rnd = {1'b0, v_reg} + (RATIO_BITS+2)'(4);
        a0    = ANGLE_BITS'(v_rnd[RATIO_BITS+1:3]);
        a1    = mul_ctl_reg.steep ? Q13_HALF_PI - a0 : a0;
        a2    = mul_ctl_reg.xneg ? Q13_PI - a1 : a1;
        angle_next = mul_ctl_reg.zero ? '0 : (mul_ctl_reg.yneg ? -a2 : a2);
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

FILE: hdl/atan2p_chk.sv
// port checker for the atan2 angle pipeline and its bind
`timescale 1ns / 1ps
module atan2p_chk
    import atan2p_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_WIDTH-1:0] coord_y,
    input logic signed [COORD_WIDTH-1:0] coord_x,
    input logic                          done,
    input logic signed [ANGLE_BITS-1:0]  angle
);

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("transaction result missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!start && $past(rst_n, LATENCY)) |-> ##LATENCY !done)
        else $error("result without transaction");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle <= Q13_PI && angle >= -Q13_PI))
        else $error("angle out of range");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (start && coord_x == '0 && coord_y == '0) |-> ##LATENCY (angle == '0))
        else $error("origin angle not zero");

endmodule

bind atan2_polynomial_approx atan2p_chk #(
    .COORD_WIDTH(COORD_WIDTH)
) u_atan2p_chk (.*);

FILE: tb/atan2_polynomial_approx_tb.sv
// self-checking testbench for the atan2 angle pipeline
`timescale 1ns / 1ps
module atan2_polynomial_approx_tb;
    import atan2p_pkg::*;

    localparam int CW = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } coord_pair_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [CW-1:0] coord_y;
    logic signed [CW-1:0] coord_x;
    logic done;
    logic signed [ANGLE_BITS-1:0] angle;

    coord_pair_t pending_pairs[$];
    logic signed [ANGLE_BITS-1:0] expected_angles[$];
    int mismatches = 0;
    int idle_left;
    int quiet_cycles = 0;
    bit calm_phase;
    bit hold_for_drain;
    bit stimulus_done;

    atan2_polynomial_approx #(.COORD_WIDTH(CW)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .coord_y(coord_y),
        .coord_x(coord_x),
        .done(done),
        .angle(angle)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint q16_floor_mul(longint a, longint m);
        if (a >= 0)
            return (a * m) >>> 16;
        return -(((-a) * m + 65535) >>> 16);
    endfunction

    function automatic logic signed [ANGLE_BITS-1:0] predict_angle(coord_pair_t p);
        longint ay;
        longint ax;
        longint big;
        longint lesser;
        longint r;
        longint s;
        longint acc;
        longint v;
        longint coefs[6];
        coefs = '{-883, 3767, -7946, 12821, -21823, 65536};
        ay = p.y < 0 ? -longint'(p.y) : longint'(p.y);
        ax = p.x < 0 ? -longint'(p.x) : longint'(p.x);
        big = ay > ax ? ay : ax;
        lesser = ay > ax ? ax : ay;
        if (big == 0)
            return '0;
        r = (lesser << 16) / big;
        if (r > 65535)
            r = 65535;
        s = (r * r) >> 16;
        acc = coefs[0];
        for (int i = 1; i < 6; i++)
            acc = q16_floor_mul(acc, s) + coefs[i];
        v = q16_floor_mul(acc, r);
        if (v < 0)
            v = 0;
        v = (v + 4) >>> 3;
        if (ay > ax)
            v = 12868 - v;
        if (p.x < 0)
            v = 25736 - v;
        if (p.y < 0)
            v = -v;
        return v[ANGLE_BITS-1:0];
    endfunction

    function automatic logic signed [CW-1:0] random_coord();
        case ($urandom_range(0, 5))
            0: return CW'($urandom_range(0, 3)) - CW'(2);
            1: return {1'b1, {(CW-1){1'b0}}} + CW'($urandom_range(0, 2));
            2: return {1'b0, {(CW-1){1'b1}}} - CW'($urandom_range(0, 2));
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
        coord_pair_t p;
        p.y = y;
        p.x = x;
        pending_pairs.push_back(p);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            coord_y <= '0;
            coord_x <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_angles.push_back(predict_angle({coord_y, coord_x}));
            if (start && busy)
                ;
            else if (idle_left > 0)
            begin
                start <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (hold_for_drain || pending_pairs.size() == 0)
                start <= 1'b0;
            else if (!calm_phase && $urandom_range(0, 9) == 0)
            begin
                start <= 1'b0;
                idle_left <= $urandom_range(0, 7);
            end
            else
            begin
                coord_pair_t p;
                p = pending_pairs.pop_front();
                start <= 1'b1;
                coord_y <= p.y;
                coord_x <= p.x;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_angles.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result angle=%0d", angle);
            end
            else
            begin
                logic signed [ANGLE_BITS-1:0] want;
                want = expected_angles.pop_front();
                if (angle !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("angle mismatch: expected %0d, actual %0d", want, angle);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        calm_phase = 1'b0;
        hold_for_drain = 1'b0;
        stimulus_done = 1'b0;
        // directed corners: origin, axes, diagonals, most negative values
        add_pair(0, 0);
        add_pair(0, 1);
        add_pair(1, 0);
        add_pair(0, -1);
        add_pair(-1, 0);
        add_pair(0, -32768);
        add_pair(-32768, 0);
        add_pair(-32768, -32768);
        add_pair(32767, 32767);
        add_pair(-32767, 32767);
        add_pair(32767, -32767);
        add_pair(-32768, 32767);
        add_pair(32767, -32768);
        add_pair(1, 32767);
        add_pair(32767, 1);
        add_pair(-1, -32768);
        add_pair(100, 100);
        add_pair(-5, -5);
        add_pair(-32768, 1);
        add_pair(21000, -12000);
        repeat (4) @(posedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < 440; i++)
            add_pair(random_coord(), random_coord());
        wait (pending_pairs.size() == 0);
        hold_for_drain = 1'b1;
        wait (expected_angles.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        hold_for_drain = 1'b0;
        for (int i = 0; i < 300; i++)
            add_pair(random_coord(), random_coord());
        wait (pending_pairs.size() == 0);
        calm_phase = 1'b1;
        for (int i = 0; i < 160; i++)
            add_pair(random_coord(), random_coord());
        wait (pending_pairs.size() == 0);
        @(posedge clk);
        @(posedge clk);
        stimulus_done = 1'b1;
        wait_cycles = 0;
        while (expected_angles.size() != 0 && wait_cycles < 10 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
